// ===== sv/btpw_pkg.sv =====
// Shared types, constants and the built-in font table of the text renderer.
// Used by every module of the block but btpw_ram; no dependencies of its own.
package btpw_pkg;

  localparam int unsigned MAX_CHARS_DEF   = 320;
  localparam int unsigned SCREEN_ROWS_DEF = 240;
  localparam int unsigned SCREEN_COLS_DEF = 320;
  localparam int unsigned GLYPH_COUNT_DEF = 41;

  localparam int unsigned GLYPH_W   = 64;
  localparam int unsigned ORIGIN_W  = 12;
  localparam int unsigned COL_W     = 14;
  localparam int unsigned ROW_W     = 13;
  localparam int unsigned PIXCOL_W  = 15;
  localparam int unsigned ADDR_W    = 16;
  localparam int unsigned COUNT_W   = 9;
  localparam int unsigned SLOT_W    = 6;
  localparam int unsigned CHAR_PITCH = 10;
  localparam int unsigned QDEPTH    = 2;

  localparam int unsigned IN_DATA_W  = 112;
  localparam int unsigned IN_USER_W  = 2;
  localparam int unsigned OUT_DATA_W = 24;

  localparam logic [1:0] KIND_BEGIN  = 2'd0;
  localparam logic [1:0] KIND_RENDER = 2'd1;
  localparam logic [1:0] KIND_LOAD   = 2'd2;

  localparam logic [SLOT_W-1:0] SLOT_BANG     = 6'd36;
  localparam logic [SLOT_W-1:0] SLOT_QUEST    = 6'd37;
  localparam logic [SLOT_W-1:0] SLOT_DOT      = 6'd38;
  localparam logic [SLOT_W-1:0] SLOT_FALLBACK = 6'd39;
  localparam logic [SLOT_W-1:0] SLOT_SPACE    = 6'd40;

  typedef struct packed {
    logic [GLYPH_W-1:0]  bits;
    logic [ORIGIN_W-1:0] row0;
    logic [COL_W-1:0]    base_col;
    logic [ADDR_W-1:0]   row_addr;
    logic [2:0]          fore;
    logic [3:0]          back;
  } glyph_job_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FLUSH
  } back_state_e;

  function automatic logic [SLOT_W-1:0] char_slot(input logic [7:0] c);
    logic [SLOT_W-1:0] s;
    if (c >= 8'h30 && c <= 8'h39) begin
      s = SLOT_W'(c - 8'h30);
    end else if (c >= 8'h41 && c <= 8'h5A) begin
      s = SLOT_W'(c - 8'h37);
    end else if (c == 8'h21) begin
      s = SLOT_BANG;
    end else if (c == 8'h3F) begin
      s = SLOT_QUEST;
    end else if (c == 8'h2E) begin
      s = SLOT_DOT;
    end else if (c == 8'h20) begin
      s = SLOT_SPACE;
    end else begin
      s = SLOT_FALLBACK;
    end
    return s;
  endfunction

  function automatic logic [GLYPH_W-1:0] font_word(input logic [SLOT_W-1:0] s);
    logic [GLYPH_W-1:0] w;
    case (s)
      6'd0:  w = 64'h7EE3F3DBCFC7C37E;
      6'd1:  w = 64'h3C7C1C1C1C1CFFFF;
      6'd2:  w = 64'h7EE7C31E7CC0C3FF;
      6'd3:  w = 64'h7EE7C31E1EC3E77E;
      6'd4:  w = 64'h1C3C6CCCFFFF0C0C;
      6'd5:  w = 64'hFFFFC0FE07C3E77E;
      6'd6:  w = 64'h7EC7C0FEE7C3E77E;
      6'd7:  w = 64'h7FFF070E1C383838;
      6'd8:  w = 64'h7EE7C37EE7C3E77E;
      6'd9:  w = 64'h7EE7C3E77F03E77E;
      6'd10: w = 64'h3C7EE7C3FFFFC3C3;
      6'd11: w = 64'hFEFFC3FEFFC3FFFE;
      6'd12: w = 64'h3F7FE0C0C0E07F3F;
      6'd13: w = 64'hFEFFC7C3C3C7FFFE;
      6'd14: w = 64'hFFFFC0FCFCC0FFFF;
      6'd15: w = 64'hFFFFC0FCFCC0C0C0;
      6'd16: w = 64'h7EFFE0CFCFE3FF7E;
      6'd17: w = 64'hC3C3C3FFFFC3C3C3;
      6'd18: w = 64'hFFFF18181818FFFF;
      6'd19: w = 64'hFFFF181818D8F870;
      6'd20: w = 64'hC7CFDCF8FCCEC7C7;
      6'd21: w = 64'hC0C0C0C0C0C0FFFF;
      6'd22: w = 64'hC3E7FFFFFFDBC3C3;
      6'd23: w = 64'hC3E3F3FBDFCFC7C3;
      6'd24: w = 64'h7EFFE7C3C3E7FF7E;
      6'd25: w = 64'hFEFFC3C3FFFEC0C0;
      6'd26: w = 64'h7EFFC3C3DBCFFE7B;
      6'd27: w = 64'hFEFFC3C3FFFCC6C7;
      6'd28: w = 64'h7FFFC0FE7F03FFFE;
      6'd29: w = 64'hFFFF181818181818;
      6'd30: w = 64'hC3C3C3C3C3FFFF7E;
      6'd31: w = 64'hC3C3C3C3E77E3C18;
      6'd32: w = 64'hC3C3DBFFFFFFE7C3;
      6'd33: w = 64'hC3E776381C6EE7C3;
      6'd34: w = 64'hC3C3C3E77E3C1818;
      6'd35: w = 64'hFFFF071E78C0FFFF;
      6'd36: w = 64'h3C7E7E3C18001818;
      6'd37: w = 64'h7EFFC31E18001818;
      6'd39: w = 64'h7F415D5D5D417F00;
      default: w = '0;
    endcase
    return w;
  endfunction

endpackage

// ===== sv/btpw_ram.sv =====
// Generic single-write, single-read RAM with a registered, enabled read port.
// No dependencies.
module btpw_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 41,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/btpw_front.sv =====
// Front end: accepts begin, render and load requests, keeps the message state
// and the glyph store, and builds one render job per drawn character.
// Depends on btpw_pkg and btpw_ram.
module btpw_front #(
  parameter int unsigned MAX_CHARS   = btpw_pkg::MAX_CHARS_DEF,
  parameter int unsigned SCREEN_COLS = btpw_pkg::SCREEN_COLS_DEF,
  parameter int unsigned GLYPH_COUNT = btpw_pkg::GLYPH_COUNT_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [btpw_pkg::IN_DATA_W-1:0] in_data_i,
  input  logic [btpw_pkg::IN_USER_W-1:0] in_user_i,
  output logic                          job_valid_o,
  input  logic                          job_ready_i,
  output btpw_pkg::glyph_job_t          job_o
);
  import btpw_pkg::*;

  localparam int unsigned AW  = $clog2(GLYPH_COUNT);
  localparam int unsigned BPR = (SCREEN_COLS + 1) / 2;

  logic                accept;
  logic [1:0]          kind;
  logic [ORIGIN_W-1:0] f_row;
  logic [ORIGIN_W-1:0] f_col;
  logic [3:0]          f_fg;
  logic [3:0]          f_bg;
  logic [7:0]          f_char;
  logic [SLOT_W-1:0]   f_slot;
  logic [GLYPH_W-1:0]  f_bits;
  logic [SLOT_W-1:0]   rslot;
  logic                render_ok;
  logic                load_ok;
  logic                push;
  logic [GLYPH_W-1:0]  ram_rdata;

  logic [ORIGIN_W-1:0] row_q;
  logic [COL_W-1:0]    col_acc_q, col_acc_d;
  logic [2:0]          fore_q;
  logic [3:0]          back_q;
  logic [COUNT_W-1:0]  count_q, count_d;
  logic [GLYPH_COUNT-1:0] vld_q, vld_d;

  logic                s1_valid_q, s1_valid_d;
  logic [ORIGIN_W-1:0] s1_row_q;
  logic [COL_W-1:0]    s1_base_q;
  logic [2:0]          s1_fore_q;
  logic [3:0]          s1_back_q;
  logic [GLYPH_W-1:0]  s1_rom_q;
  logic                s1_vld_q;

  assign kind   = in_user_i;
  assign f_row  = in_data_i[11:0];
  assign f_col  = in_data_i[23:12];
  assign f_fg   = in_data_i[27:24];
  assign f_bg   = in_data_i[31:28];
  assign f_char = in_data_i[39:32];
  assign f_slot = in_data_i[45:40];
  assign f_bits = in_data_i[109:46];

  assign in_ready_o = !s1_valid_q || job_ready_i;
  assign accept     = in_valid_i && in_ready_o;
  assign rslot      = char_slot(f_char);
  assign render_ok  = accept && (kind == KIND_RENDER) && (count_q < COUNT_W'(MAX_CHARS));
  assign load_ok    = accept && (kind == KIND_LOAD) &&
                      ({1'b0, f_slot} < (SLOT_W + 1)'(GLYPH_COUNT));
  assign push       = s1_valid_q && job_ready_i;

  btpw_ram #(
    .WIDTH(GLYPH_W),
    .DEPTH(GLYPH_COUNT)
  ) u_glyph_ram (
    .clk_i  (clk_i),
    .we_i   (load_ok),
    .waddr_i(f_slot[AW-1:0]),
    .wdata_i(f_bits),
    .re_i   (render_ok),
    .raddr_i(rslot[AW-1:0]),
    .rdata_o(ram_rdata)
  );

  always_comb begin
    count_d   = count_q;
    col_acc_d = col_acc_q;
    vld_d     = vld_q;
    if (accept && kind == KIND_BEGIN) begin
      count_d   = '0;
      col_acc_d = COL_W'(f_col);
    end
    if (render_ok) begin
      count_d   = count_q + 1'b1;
      col_acc_d = col_acc_q + COL_W'(CHAR_PITCH);
    end
    if (load_ok) begin
      vld_d[f_slot[AW-1:0]] = 1'b1;
    end
    if (render_ok) begin
      s1_valid_d = 1'b1;
    end else if (push) begin
      s1_valid_d = 1'b0;
    end else begin
      s1_valid_d = s1_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q      <= '0;
      col_acc_q  <= '0;
      fore_q     <= '0;
      back_q     <= 4'h8;
      count_q    <= '0;
      vld_q      <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      if (accept && kind == KIND_BEGIN) begin
        row_q  <= f_row;
        fore_q <= f_fg[2:0];
        back_q <= f_bg;
      end
      col_acc_q  <= col_acc_d;
      count_q    <= count_d;
      vld_q      <= vld_d;
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (render_ok) begin
      s1_row_q  <= row_q;
      s1_base_q <= col_acc_q;
      s1_fore_q <= fore_q;
      s1_back_q <= back_q;
      s1_rom_q  <= font_word(rslot);
      s1_vld_q  <= vld_q[rslot[AW-1:0]];
    end
  end

  always_comb begin
    job_o.bits     = s1_vld_q ? ram_rdata : s1_rom_q;
    job_o.row0     = s1_row_q;
    job_o.base_col = s1_base_q;
    job_o.row_addr = ADDR_W'(s1_row_q * BPR);
    job_o.fore     = s1_fore_q;
    job_o.back     = s1_back_q;
  end

  assign job_valid_o = s1_valid_q;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= COUNT_W'(MAX_CHARS))
    else $error("character count passed the message limit");
  a_full_no_job: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && kind == KIND_RENDER && count_q == COUNT_W'(MAX_CHARS) && !push && !s1_valid_q)
    |=> !s1_valid_q)
    else $error("render job built for a full message");
`endif

endmodule

// ===== sv/btpw_queue.sv =====
// Short job queue between the front end and the pixel scanner.
// Depends on btpw_pkg.
module btpw_queue (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_valid_i,
  output logic                 push_ready_o,
  input  btpw_pkg::glyph_job_t push_data_i,
  output logic                 pop_valid_o,
  input  logic                 pop_i,
  output btpw_pkg::glyph_job_t pop_data_o
);
  import btpw_pkg::*;

  localparam int unsigned PW = $clog2(QDEPTH);

  glyph_job_t              slot_q [QDEPTH];
  logic [PW-1:0]           wr_ptr_q, rd_ptr_q;
  logic [$clog2(QDEPTH+1)-1:0] cnt_q;
  logic                    do_push;
  logic                    do_pop;

  assign push_ready_o = cnt_q != ($clog2(QDEPTH+1))'(QDEPTH);
  assign pop_valid_o  = cnt_q != '0;
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_i && pop_valid_o;
  assign pop_data_o   = slot_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PW'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PW'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

`ifndef SYNTHESIS
  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> pop_valid_o)
    else $error("job popped from an empty queue");
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_valid_i && !push_ready_o |=> $stable(cnt_q) || $past(do_pop))
    else $error("queue fill changed on a refused job");
`endif

endmodule

// ===== sv/btpw_back.sv =====
// Back end: scans one glyph job pixel by pixel and emits nibble writes,
// holding one write back so the final one carries the last flag.
// Depends on btpw_pkg.
module btpw_back #(
  parameter int unsigned SCREEN_ROWS = btpw_pkg::SCREEN_ROWS_DEF,
  parameter int unsigned SCREEN_COLS = btpw_pkg::SCREEN_COLS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 job_valid_i,
  output logic                 job_pop_o,
  input  btpw_pkg::glyph_job_t job_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [btpw_pkg::OUT_DATA_W-1:0] out_data_o,
  output logic                 out_last_o
);
  import btpw_pkg::*;

  localparam int unsigned BPR = (SCREEN_COLS + 1) / 2;

  back_state_e state_q, state_d;
  logic [5:0]         idx_q;
  glyph_job_t         job_q;
  logic               step;
  logic               on;
  logic [ROW_W-1:0]   r;
  logic [PIXCOL_W-1:0] c;
  logic               draw;
  logic [2:0]         color;
  logic [ADDR_W-1:0]  addr;
  logic               emit_pend;
  logic               load_pend;

  logic               pend_valid_q;
  logic [ADDR_W-1:0]  pend_addr_q;
  logic               pend_hi_q;
  logic [3:0]         pend_nib_q;

  logic               out_valid_q;
  logic [ADDR_W-1:0]  out_addr_q;
  logic               out_hi_q;
  logic [3:0]         out_nib_q;
  logic               out_last_q;

  assign step  = !out_valid_q || out_ready_i;
  assign on    = job_q.bits[GLYPH_W-1];
  assign r     = ROW_W'(job_q.row0) + ROW_W'(idx_q[5:3]);
  assign c     = PIXCOL_W'(job_q.base_col) + PIXCOL_W'(idx_q[2:0]);
  assign draw  = (on || !job_q.back[3]) && (r < ROW_W'(SCREEN_ROWS)) &&
                 (c < PIXCOL_W'(SCREEN_COLS));
  assign color = on ? job_q.fore : job_q.back[2:0];
  assign addr  = job_q.row_addr + ADDR_W'(c[PIXCOL_W-1:1]);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (job_valid_i) begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (step && idx_q == 6'd63) begin
          state_d = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        if (step) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    job_pop_o = 1'b0;
    emit_pend = 1'b0;
    load_pend = 1'b0;
    case (state_q)
      ST_IDLE: begin
        job_pop_o = job_valid_i;
      end
      ST_SCAN: begin
        load_pend = step && draw;
        emit_pend = step && draw && pend_valid_q;
      end
      ST_FLUSH: begin
        emit_pend = step && pend_valid_q;
      end
      default: begin
        job_pop_o = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      idx_q        <= '0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (job_pop_o) begin
        idx_q <= '0;
      end else if (state_q == ST_SCAN && step) begin
        idx_q <= idx_q + 1'b1;
      end
      if (load_pend) begin
        pend_valid_q <= 1'b1;
      end else if (emit_pend) begin
        pend_valid_q <= 1'b0;
      end
      if (emit_pend) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (job_pop_o) begin
      job_q <= job_i;
    end else if (state_q == ST_SCAN && step) begin
      job_q.bits <= {job_q.bits[GLYPH_W-2:0], 1'b0};
      if (idx_q[2:0] == 3'd7) begin
        job_q.row_addr <= job_q.row_addr + ADDR_W'(BPR);
      end
    end
    if (load_pend) begin
      pend_addr_q <= addr;
      pend_hi_q   <= !c[0];
      pend_nib_q  <= {color, 1'b0};
    end
    if (emit_pend) begin
      out_addr_q <= pend_addr_q;
      out_hi_q   <= pend_hi_q;
      out_nib_q  <= pend_nib_q;
      out_last_q <= state_q == ST_FLUSH;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = {3'b000, out_nib_q, out_hi_q, out_addr_q};
  assign out_last_o  = out_last_q;

`ifndef SYNTHESIS
  a_flush_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FLUSH && step && pend_valid_q) |=> out_valid_o && out_last_o)
    else $error("final write of a character left without last flag");
  a_idle_no_pend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_IDLE |-> !pend_valid_q)
    else $error("held write survived the end of a character");
`endif

endmodule

// ===== sv/bitmap_text_to_pixel_writes_core.sv =====
// Top level of the 8x8 bitmap text renderer: nibble writes into a packed
// two-pixels-per-byte framebuffer. Depends on btpw_pkg, btpw_front,
// btpw_queue and btpw_back.
//
// Input stream (s_axis): tuser carries the request kind (begin, render,
// load); tdata carries the begin origin and colors, the character code and
// the glyph load slot and bitmap. Begin and load requests give no writes.
// A render request yields up to 64 writes on the output stream (m_axis):
// tdata carries byte address, nibble select and nibble value, tlast marks
// the final write of the character.
// A character's first write leaves sooner when its first two pixels draw,
// later when leading pixels are dropped.
// Throughput: the pixel scanner loads a job, walks all 64 glyph positions
// one per cycle while m_axis takes its writes, then releases the held
// final write. Two jobs queue ahead of it, so requests keep flowing
// while a character is drawn.
// Reset: the glyph store reads the built-in font until a slot is loaded;
// no clearing pass is needed. When m_axis stalls, the scanner holds and
// the queue then fills and drops s_axis_tready_o.
module bitmap_text_to_pixel_writes_core #(
  parameter int unsigned MAX_CHARS   = btpw_pkg::MAX_CHARS_DEF,
  parameter int unsigned SCREEN_ROWS = btpw_pkg::SCREEN_ROWS_DEF,
  parameter int unsigned SCREEN_COLS = btpw_pkg::SCREEN_COLS_DEF,
  parameter int unsigned GLYPH_COUNT = btpw_pkg::GLYPH_COUNT_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  // start_row, start_col, fg_color, bg_color, char_code, glyph_slot, glyph_bits
  input  logic [btpw_pkg::IN_DATA_W-1:0]  s_axis_tdata_i,
  // kind
  input  logic [btpw_pkg::IN_USER_W-1:0]  s_axis_tuser_i,
  output logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i,
  // byte_address, high_nibble, nibble_value
  output logic [btpw_pkg::OUT_DATA_W-1:0] m_axis_tdata_o,
  output logic                            m_axis_tlast_o
);
  import btpw_pkg::*;

  logic       f_valid;
  logic       q_ready;
  glyph_job_t f_job;
  logic       q_valid;
  logic       q_pop;
  glyph_job_t q_job;

  btpw_front #(
    .MAX_CHARS  (MAX_CHARS),
    .SCREEN_COLS(SCREEN_COLS),
    .GLYPH_COUNT(GLYPH_COUNT)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .in_data_i  (s_axis_tdata_i),
    .in_user_i  (s_axis_tuser_i),
    .job_valid_o(f_valid),
    .job_ready_i(q_ready),
    .job_o      (f_job)
  );

  btpw_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_valid_i(f_valid),
    .push_ready_o(q_ready),
    .push_data_i (f_job),
    .pop_valid_o (q_valid),
    .pop_i       (q_pop),
    .pop_data_o  (q_job)
  );

  btpw_back #(
    .SCREEN_ROWS(SCREEN_ROWS),
    .SCREEN_COLS(SCREEN_COLS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .job_valid_i(q_valid),
    .job_pop_o  (q_pop),
    .job_i      (q_job),
    .out_valid_o(m_axis_tvalid_o),
    .out_ready_i(m_axis_tready_i),
    .out_data_o (m_axis_tdata_o),
    .out_last_o (m_axis_tlast_o)
  );

endmodule
